### sv/nfha_pkg.sv
package nfha_pkg;

  // heap geometry
  localparam int HEAP_DEPTH    = 1024;
  localparam int GRANULE_BYTES = 64;
  localparam int LOG2G         = $clog2(GRANULE_BYTES);
  localparam int HDR_BYTES     = 8;

  // field and datapath widths
  localparam int ADDR_W  = 16;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = $clog2(HEAP_DEPTH);
  localparam int SIZE_W  = $clog2(2 * HEAP_DEPTH);
  localparam int GIDX_W  = ADDR_W - LOG2G;
  localparam int ARITH_W = ADDR_W + 1;
  localparam int NEED_W  = ARITH_W - LOG2G;

  // merged block sizes saturate here
  localparam int SAT_LIMIT = 2 * HEAP_DEPTH;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SAT_LIMIT - 1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_CORRUPT = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NEED,
    S_FIT,
    S_RD,
    S_CHK,
    S_ADV,
    S_SPLIT,
    S_MARK,
    S_FCHK,
    S_FHD,
    S_FNX,
    S_FMG,
    S_FWR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    alu_op_e            op;
    logic [ARITH_W-1:0] a;
    logic [ARITH_W-1:0] b;
    logic [ARITH_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ARITH_W-1:0] r;
    logic               borrow;
    logic               lt;
    logic               eq;
  } alu_rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    hdr_t              wr_data;
    logic              init_set;
    logic [SIZE_W-1:0] lim;
  } mem_req_t;

endpackage

### sv/nfha_req_if.sv
interface nfha_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [nfha_pkg::ADDR_W-1:0] request_bytes;
  logic [nfha_pkg::ADDR_W-1:0] block_address;

  modport source (output valid, output operation, output request_bytes,
                  output block_address, input ready);
  modport sink (input valid, input operation, input request_bytes,
                input block_address, output ready);
endinterface

### sv/nfha_rsp_if.sv
interface nfha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [nfha_pkg::ADDR_W-1:0] payload_address;

  modport source (output valid, output status, output payload_address, input ready);
  modport sink (input valid, input status, input payload_address, output ready);
endinterface

### sv/nfha_cfg_if.sv
interface nfha_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nfha_pkg::CFG_W-1:0] heap_granules;

  modport source (output valid, output heap_granules, input ready);
  modport sink (input valid, input heap_granules, output ready);
endinterface

### sv/next_fit_heap_allocator_unit.sv
// channel | dir | beat moves                                    | accepted when
// req_i   | in  | operation, request_bytes, block_address       | valid && ready
// rsp_o   | out | status, payload_address                       | valid && ready
// cfg_i   | in  | heap_granules (heap size, reinitialises heap) | valid && ready
//
// allocate: NEED, FIT, RD, CHK, an ADV and CHK per header stepped over, SPLIT, MARK if split, RESP
// free: FCHK, RD, FHD, FNX, an FMG and FNX per merged neighbour, FWR, RESP; a busy or zero-size
// header ends it via FMG; a dropped free goes FCHK to RESP; all use the header store and one adder
// reset: heap is one free block of HEAP_DEPTH granules at once, no clearing pass
// rsp_o stall: one result waits in the output register; a request can be taken meanwhile
module next_fit_heap_allocator_unit (
  input logic        clk_i,
  input logic        rst_ni,
  nfha_req_if.sink   req_i,
  nfha_rsp_if.source rsp_o,
  nfha_cfg_if.sink   cfg_i
);
  import nfha_pkg::*;

  // shared add/subtract with compare, driven by the sequencer every cycle
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // header store: one read or one write per cycle, registered read data
  mem_req_t mem_req;
  hdr_t     mem_rd;

  // sequencer: request decode, next-fit walk, split, merge and result register
  nfha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .cfg_i     (cfg_i),
    .alu_req_o (alu_req),
    .alu_rsp_i (alu_rsp),
    .mem_req_o (mem_req),
    .mem_rd_i  (mem_rd)
  );

  // granule rounding, fit checks, header stepping and merge sums all go through here
  nfha_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // block headers indexed by first granule; entry zero held as whole-heap until written
  nfha_hdr_ram u_hdr_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

endmodule

### sv/nfha_alu.sv
module nfha_alu (
  input  nfha_pkg::alu_req_t req_i,
  output nfha_pkg::alu_rsp_t rsp_o
);
  import nfha_pkg::*;

  logic [ARITH_W:0] wide;

  always_comb begin
    if (req_i.op == ALU_SUB) begin
      wide = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      wide = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

  assign rsp_o.r      = wide[ARITH_W-1:0];
  assign rsp_o.borrow = wide[ARITH_W];
  assign rsp_o.lt     = (wide[ARITH_W-1:0] < req_i.c);
  assign rsp_o.eq     = (wide[ARITH_W-1:0] == req_i.c);

endmodule

### sv/nfha_hdr_ram.sv
module nfha_hdr_ram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nfha_pkg::mem_req_t req_i,
  output nfha_pkg::hdr_t     rd_data_o
);
  import nfha_pkg::*;

  hdr_t mem [HEAP_DEPTH];
  hdr_t rd_data_q;
  logic rd_ovr_q;
  logic init_q;

  // entry zero reads as one free block over the heap until it is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
    end else if (req_i.init_set) begin
      init_q <= 1'b1;
    end else if (req_i.wr_en && (req_i.wr_addr == '0)) begin
      init_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
      rd_ovr_q  <= init_q && (req_i.rd_addr == '0);
    end
  end

  always_comb begin
    if (rd_ovr_q) begin
      rd_data_o = '{busy: 1'b0, size: req_i.lim};
    end else begin
      rd_data_o = rd_data_q;
    end
  end

endmodule

### sv/nfha_ctrl.sv
module nfha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  nfha_req_if.sink           req_i,
  nfha_rsp_if.source         rsp_o,
  nfha_cfg_if.sink           cfg_i,
  output nfha_pkg::alu_req_t alu_req_o,
  input  nfha_pkg::alu_rsp_t alu_rsp_i,
  output nfha_pkg::mem_req_t mem_req_o,
  input  nfha_pkg::hdr_t     mem_rd_i
);
  import nfha_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [ADDR_W-1:0]  bytes_q, bytes_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [NEED_W-1:0]  need_q, need_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [SIZE_W-1:0]  sz_q, sz_d;
  logic [SIZE_W-1:0]  rem_q, rem_d;
  logic               err_q, err_d;
  status_e            res_status_q, res_status_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [SIZE_W-1:0]  lim_q, lim_d;
  logic [IDX_W-1:0]   nf_q, nf_d;
  logic               rsp_valid_q, rsp_valid_d;
  status_e            rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]  rsp_addr_q, rsp_addr_d;

  logic [GIDX_W-1:0]  free_g;
  logic [ADDR_W-1:0]  alloc_addr;
  logic [CFG_W-1:0]   cfg_v;

  assign free_g     = addr_q[ADDR_W-1:LOG2G];
  assign alloc_addr = {cur_q, {LOG2G{1'b0}}} | ADDR_W'(HDR_BYTES);
  assign cfg_v      = cfg_i.heap_granules;

  assign req_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready          = 1'b1;
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.payload_address = rsp_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lim_q       <= SIZE_W'(HEAP_DEPTH);
      nf_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lim_q       <= lim_d;
      nf_q        <= nf_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    bytes_q      <= bytes_d;
    addr_q       <= addr_d;
    need_q       <= need_d;
    cur_q        <= cur_d;
    sz_q         <= sz_d;
    rem_q        <= rem_d;
    err_q        <= err_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    rsp_status_q <= rsp_status_d;
    rsp_addr_q   <= rsp_addr_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    bytes_d      = bytes_q;
    addr_d       = addr_q;
    need_d       = need_q;
    cur_d        = cur_q;
    sz_d         = sz_q;
    rem_d        = rem_q;
    err_d        = err_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    lim_d        = lim_q;
    nf_d         = nf_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_addr_d   = rsp_addr_q;

    alu_req_o = '{op: ALU_ADD, a: '0, b: '0, c: '0};

    mem_req_o          = '0;
    mem_req_o.rd_addr  = cur_q;
    mem_req_o.wr_addr  = cur_q;
    mem_req_o.lim      = lim_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = op_e'(req_i.operation);
          bytes_d = req_i.request_bytes;
          addr_d  = req_i.block_address;
          state_d = (op_e'(req_i.operation) == OP_FREE) ? S_FCHK : S_NEED;
        end
      end

      // granules needed, header included, rounded up
      S_NEED: begin
        alu_req_o.a = ARITH_W'(bytes_q);
        alu_req_o.b = ARITH_W'(HDR_BYTES + GRANULE_BYTES - 1);
        need_d      = NEED_W'(alu_rsp_i.r >> LOG2G);
        state_d     = S_FIT;
      end

      // start at the next-fit point only if the request still fits above it
      S_FIT: begin
        alu_req_o.a = ARITH_W'(nf_q);
        alu_req_o.b = ARITH_W'(need_q);
        alu_req_o.c = ARITH_W'(lim_q);
        cur_d       = (alu_rsp_i.lt || alu_rsp_i.eq) ? nf_q : '0;
        state_d     = S_RD;
      end

      S_RD: begin
        mem_req_o.rd_en = 1'b1;
        state_d         = (op_q == OP_FREE) ? S_FHD : S_CHK;
      end

      S_CHK: begin
        alu_req_o.op = ALU_SUB;
        alu_req_o.a  = ARITH_W'(mem_rd_i.size);
        alu_req_o.b  = ARITH_W'(need_q);
        sz_d         = mem_rd_i.size;
        rem_d        = SIZE_W'(alu_rsp_i.r);
        if (mem_rd_i.size == '0) begin
          res_status_d = ST_CORRUPT;
          res_addr_d   = '0;
          state_d      = S_RESP;
        end else if (!mem_rd_i.busy && !alu_rsp_i.borrow) begin
          state_d = S_SPLIT;
        end else begin
          state_d = S_ADV;
        end
      end

      S_ADV: begin
        alu_req_o.a = ARITH_W'(cur_q);
        alu_req_o.b = ARITH_W'(sz_q);
        alu_req_o.c = ARITH_W'(lim_q);
        if (alu_rsp_i.lt) begin
          cur_d             = IDX_W'(alu_rsp_i.r);
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = IDX_W'(alu_rsp_i.r);
          state_d           = S_CHK;
        end else begin
          res_status_d = ST_OOM;
          res_addr_d   = '0;
          state_d      = S_RESP;
        end
      end

      // remainder header first, then busy header, else whole block busy
      S_SPLIT: begin
        alu_req_o.a = ARITH_W'(cur_q);
        alu_req_o.b = ARITH_W'(need_q);
        alu_req_o.c = ARITH_W'(lim_q);
        if ((rem_q != '0) && alu_rsp_i.lt) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = IDX_W'(alu_rsp_i.r);
          mem_req_o.wr_data = '{busy: 1'b0, size: rem_q};
          nf_d              = IDX_W'(alu_rsp_i.r);
          state_d           = S_MARK;
        end else begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_data = '{busy: 1'b1, size: sz_q};
          res_status_d      = ST_OK;
          res_addr_d        = alloc_addr;
          state_d           = S_RESP;
        end
      end

      S_MARK: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_data = '{busy: 1'b1, size: SIZE_W'(need_q)};
        res_status_d      = ST_OK;
        res_addr_d        = alloc_addr;
        state_d           = S_RESP;
      end

      // null, misaligned or out-of-range frees are dropped quietly
      S_FCHK: begin
        alu_req_o.a = ARITH_W'(free_g);
        alu_req_o.c = ARITH_W'(lim_q);
        err_d       = 1'b0;
        if ((addr_q[LOG2G-1:0] != LOG2G'(HDR_BYTES)) || !alu_rsp_i.lt) begin
          res_status_d = ST_OK;
          res_addr_d   = '0;
          state_d      = S_RESP;
        end else begin
          cur_d   = IDX_W'(free_g);
          state_d = S_RD;
        end
      end

      S_FHD: begin
        if (mem_rd_i.size == '0) begin
          res_status_d = ST_CORRUPT;
          res_addr_d   = '0;
          state_d      = S_RESP;
        end else begin
          sz_d    = mem_rd_i.size;
          state_d = S_FNX;
        end
      end

      S_FNX: begin
        alu_req_o.a = ARITH_W'(cur_q);
        alu_req_o.b = ARITH_W'(sz_q);
        alu_req_o.c = ARITH_W'(lim_q);
        if (alu_rsp_i.lt) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = IDX_W'(alu_rsp_i.r);
          state_d           = S_FMG;
        end else begin
          state_d = S_FWR;
        end
      end

      S_FMG: begin
        alu_req_o.a = ARITH_W'(sz_q);
        alu_req_o.b = ARITH_W'(mem_rd_i.size);
        alu_req_o.c = ARITH_W'(SAT_LIMIT);
        priority if (mem_rd_i.busy) begin
          state_d = S_FWR;
        end else if (mem_rd_i.size == '0) begin
          err_d   = 1'b1;
          state_d = S_FWR;
        end else begin
          sz_d    = alu_rsp_i.lt ? SIZE_W'(alu_rsp_i.r) : SIZE_CAP;
          state_d = S_FNX;
        end
      end

      S_FWR: begin
        alu_req_o.a       = ARITH_W'(cur_q);
        alu_req_o.c       = ARITH_W'(nf_q);
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_data = '{busy: 1'b0, size: sz_q};
        if (alu_rsp_i.lt) begin
          nf_d = cur_q;
        end
        res_status_d = err_q ? ST_CORRUPT : ST_OK;
        res_addr_d   = '0;
        state_d      = S_RESP;
      end

      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // heap size write: zero reads as one granule, saturate at the depth
    if (cfg_i.valid) begin
      priority if (cfg_v == '0) begin
        lim_d = SIZE_W'(1);
      end else if (cfg_v > CFG_W'(HEAP_DEPTH)) begin
        lim_d = SIZE_W'(HEAP_DEPTH);
      end else begin
        lim_d = SIZE_W'(cfg_v);
      end
      nf_d               = '0;
      mem_req_o.init_set = 1'b1;
    end
  end

  // next-fit point always lies inside the heap
  a_nf_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SIZE_W'(nf_q) < lim_q)
    else $error("next-fit index outside heap");

  // header writes never land past the limit
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (SIZE_W'(mem_req_o.wr_addr) < lim_q))
    else $error("header write beyond heap limit");

  // every header examined by the search lies inside the heap
  a_walk_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (SIZE_W'(cur_q) < lim_q))
    else $error("search walked past heap limit");

  // a non-null address is only ever a header granule plus the header bytes
  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_addr_q != '0)) |->
      ((rsp_status_q == ST_OK) && (rsp_addr_q[LOG2G-1:0] == LOG2G'(HDR_BYTES))))
    else $error("malformed payload address");

  // a response is only produced from the response state
  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("response raised outside response state");

endmodule
